[rtl/pcapdf_pkg.sv]
// ----------------------------------------------------------------------------
// pcapdf_pkg
// Types, constants and helpers for the capture-file stream deframer.
// ----------------------------------------------------------------------------
package pcapdf_pkg;

    localparam int GLOBAL_HDR_LEN = 24;
    localparam int RECORD_HDR_LEN = 16;
    localparam int POS_W          = $clog2(GLOBAL_HDR_LEN);
    localparam int TDATA_W        = 240;
    localparam int TUSER_W        = 3;

    localparam logic [7:0] MAGIC_D4 = 8'hd4;
    localparam logic [7:0] MAGIC_C3 = 8'hc3;
    localparam logic [7:0] MAGIC_B2 = 8'hb2;
    localparam logic [7:0] MAGIC_A1 = 8'ha1;
    localparam logic [7:0] MAGIC_4D = 8'h4d;
    localparam logic [7:0] MAGIC_3C = 8'h3c;

    // format bits
    localparam logic [1:0] FMT_LE_US = 2'd0;
    localparam logic [1:0] FMT_BE_US = 2'd1;
    localparam logic [1:0] FMT_LE_NS = 2'd2;
    localparam logic [1:0] FMT_BE_NS = 2'd3;

    typedef enum logic [1:0] {
        PH_FILE_HDR = 2'd0,
        PH_REC_HDR  = 2'd1,
        PH_PAYLOAD  = 2'd2,
        PH_SKIP     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        K_FILE_HDR  = 3'd0,
        K_REC_HDR   = 3'd1,
        K_PAYLOAD   = 3'd2,
        K_BAD_MAGIC = 3'd3,
        K_TRUNC     = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  format;
        logic [15:0] ver_major;
        logic [15:0] ver_minor;
        logic [31:0] snap_length;
        logic [31:0] link_type;
        logic [31:0] seconds;
        logic [31:0] subseconds;
        logic [31:0] captured_length;
        logic [31:0] original_length;
        logic [7:0]  payload_byte;
        logic        end_of_record;
    } result_t;

    function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic big);
        return big ? {b0, b1} : {b1, b0};
    endfunction

    function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic big);
        return big ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    function automatic result_t blank_result(input kind_t k, input logic [1:0] fmt);
        result_t r;
        r        = '0;
        r.kind   = k;
        r.format = fmt;
        return r;
    endfunction

endpackage

[rtl/pcap_stream_deframer_core.sv]
// ----------------------------------------------------------------------------
// pcap_stream_deframer_core
// Capture-file deframer: file header, record headers and payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one file byte per item in s_tdata[7:0], s_tlast on the file's last byte.
//   m_* : one result per item; m_tuser = kind, m_tlast = end of record,
//         m_tdata = decoded header words or the payload byte.
//   A byte gives zero, one or two results (a header or payload result, then
//   possibly a truncated report). The magic picks byte order and resolution;
//   a bad magic is reported once and later bytes are dropped until s_tlast.
// The first result of a byte is registered and appears in the cycle after acceptance.
// Throughput: one byte per cycle while each byte gives at most one result and
//   m_tready is high; a byte giving two results holds the input until the first
//   is taken and the second is being taken. The two-entry queue at m_* sets the rate.
// Reset: back to expecting a file header, result queue empty.
// Stall: when m_tready is low s_tready drops while any result is queued; nothing is
//   lost and no byte is taken until the queue has room for two results.
// ----------------------------------------------------------------------------
module pcap_stream_deframer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // file_byte
    input  logic                          s_tlast,   // end_of_file
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // format, ver_major, ver_minor, snap_length, link_type, seconds,
    // subseconds, captured_length, original_length, payload_byte, zero pad
    output logic [pcapdf_pkg::TDATA_W-1:0] m_tdata,
    output logic [pcapdf_pkg::TUSER_W-1:0] m_tuser,  // kind
    output logic                          m_tlast    // end_of_record
);

    localparam int POS_W = pcapdf_pkg::POS_W;

    pcapdf_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]         fmt_reg, fmt_next;
    logic [31:0]        rem_reg, rem_next;
    logic [7:0]         header_bytes_reg [pcapdf_pkg::GLOBAL_HDR_LEN];
    logic [7:0]         hv [pcapdf_pkg::GLOBAL_HDR_LEN];

    pcapdf_pkg::result_t q_reg [2];
    logic [1:0]          cnt_reg, cnt_next;

    pcapdf_pkg::result_t r0, r1;
    logic [1:0]          n_res;
    logic                bad_magic;
    logic                big;
    logic [31:0]         cap_len;
    logic                pay_last;
    logic                accept, pop;
    logic [7:0]          b;
    logic                eof;

    assign b      = s_tdata;
    assign eof    = s_tlast;
    assign pop    = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign accept = s_tvalid && s_tready;

    // stored header bytes with the current byte laid over its slot
    always_comb
    begin
        hv = header_bytes_reg;
        if (phase_reg == pcapdf_pkg::PH_FILE_HDR || phase_reg == pcapdf_pkg::PH_REC_HDR)
        begin
            hv[pos_reg] = b;
        end
    end

    assign big      = fmt_next[0];
    assign cap_len  = pcapdf_pkg::get32(hv[8], hv[9], hv[10], hv[11], big);
    assign pay_last = (rem_reg[31:1] == 31'd0);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        fmt_next   = fmt_reg;
        rem_next   = rem_reg;
        n_res      = 2'd0;
        bad_magic  = 1'b0;
        case (phase_reg)
            pcapdf_pkg::PH_FILE_HDR:
            begin
                if (pos_reg == POS_W'(3))
                begin
                    if (hv[0] == pcapdf_pkg::MAGIC_D4 && hv[1] == pcapdf_pkg::MAGIC_C3 &&
                        hv[2] == pcapdf_pkg::MAGIC_B2 && hv[3] == pcapdf_pkg::MAGIC_A1)
                        fmt_next = pcapdf_pkg::FMT_LE_US;
                    else if (hv[0] == pcapdf_pkg::MAGIC_A1 && hv[1] == pcapdf_pkg::MAGIC_B2 &&
                             hv[2] == pcapdf_pkg::MAGIC_C3 && hv[3] == pcapdf_pkg::MAGIC_D4)
                        fmt_next = pcapdf_pkg::FMT_BE_US;
                    else if (hv[0] == pcapdf_pkg::MAGIC_4D && hv[1] == pcapdf_pkg::MAGIC_3C &&
                             hv[2] == pcapdf_pkg::MAGIC_B2 && hv[3] == pcapdf_pkg::MAGIC_A1)
                        fmt_next = pcapdf_pkg::FMT_LE_NS;
                    else if (hv[0] == pcapdf_pkg::MAGIC_A1 && hv[1] == pcapdf_pkg::MAGIC_B2 &&
                             hv[2] == pcapdf_pkg::MAGIC_3C && hv[3] == pcapdf_pkg::MAGIC_4D)
                        fmt_next = pcapdf_pkg::FMT_BE_NS;
                    else
                    begin
                        fmt_next  = pcapdf_pkg::FMT_LE_US;
                        bad_magic = 1'b1;
                    end
                end
                if (bad_magic)
                begin
                    n_res      = 2'd1;
                    phase_next = pcapdf_pkg::PH_SKIP;
                end
                else if (pos_reg == POS_W'(pcapdf_pkg::GLOBAL_HDR_LEN - 1))
                begin
                    n_res      = 2'd1;
                    phase_next = pcapdf_pkg::PH_REC_HDR;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                    n_res    = eof ? 2'd1 : 2'd0;
                end
            end
            pcapdf_pkg::PH_REC_HDR:
            begin
                if (pos_reg == POS_W'(pcapdf_pkg::RECORD_HDR_LEN - 1))
                begin
                    pos_next = '0;
                    rem_next = cap_len;
                    n_res    = 2'd1;
                    if (cap_len != 32'd0)
                    begin
                        phase_next = pcapdf_pkg::PH_PAYLOAD;
                        n_res      = eof ? 2'd2 : 2'd1;
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                    n_res    = eof ? 2'd1 : 2'd0;
                end
            end
            pcapdf_pkg::PH_PAYLOAD:
            begin
                rem_next = (rem_reg == 32'd0) ? 32'd0 : rem_reg - 32'd1;
                if (pay_last)
                begin
                    phase_next = pcapdf_pkg::PH_REC_HDR;
                    pos_next   = '0;
                    n_res      = 2'd1;
                end
                else
                begin
                    n_res = eof ? 2'd2 : 2'd1;
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
        if (eof)
        begin
            phase_next = pcapdf_pkg::PH_FILE_HDR;
            pos_next   = '0;
            rem_next   = '0;
        end
    end

    // results of the current byte; a second result is always a truncated report
    always_comb
    begin
        r0 = pcapdf_pkg::blank_result(pcapdf_pkg::K_TRUNC, fmt_next);
        r1 = pcapdf_pkg::blank_result(pcapdf_pkg::K_TRUNC, fmt_next);
        case (phase_reg)
            pcapdf_pkg::PH_FILE_HDR:
            begin
                if (bad_magic)
                begin
                    r0 = pcapdf_pkg::blank_result(pcapdf_pkg::K_BAD_MAGIC, 2'd0);
                end
                else if (pos_reg == POS_W'(pcapdf_pkg::GLOBAL_HDR_LEN - 1))
                begin
                    r0 = pcapdf_pkg::blank_result(pcapdf_pkg::K_FILE_HDR, fmt_next);
                    r0.ver_major   = pcapdf_pkg::get16(hv[4], hv[5], big);
                    r0.ver_minor   = pcapdf_pkg::get16(hv[6], hv[7], big);
                    r0.snap_length = pcapdf_pkg::get32(hv[16], hv[17], hv[18], hv[19], big);
                    r0.link_type   = pcapdf_pkg::get32(hv[20], hv[21], hv[22], hv[23], big);
                end
            end
            pcapdf_pkg::PH_REC_HDR:
            begin
                if (pos_reg == POS_W'(pcapdf_pkg::RECORD_HDR_LEN - 1))
                begin
                    r0 = pcapdf_pkg::blank_result(pcapdf_pkg::K_REC_HDR, fmt_next);
                    r0.seconds         = pcapdf_pkg::get32(hv[0], hv[1], hv[2], hv[3], big);
                    r0.subseconds      = pcapdf_pkg::get32(hv[4], hv[5], hv[6], hv[7], big);
                    r0.captured_length = cap_len;
                    r0.original_length = pcapdf_pkg::get32(hv[12], hv[13], hv[14], hv[15],
                                                           big);
                    r0.end_of_record   = (cap_len == 32'd0);
                end
            end
            pcapdf_pkg::PH_PAYLOAD:
            begin
                r0 = pcapdf_pkg::blank_result(pcapdf_pkg::K_PAYLOAD, fmt_next);
                r0.payload_byte  = b;
                r0.end_of_record = pay_last;
            end
            default:
            begin
                r0 = pcapdf_pkg::blank_result(pcapdf_pkg::K_TRUNC, fmt_next);
            end
        endcase
    end

    // queue count: on accept the queue is empty after this cycle's pop
    always_comb
    begin
        cnt_next = cnt_reg - {1'b0, pop};
        if (accept)
        begin
            cnt_next = n_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pcapdf_pkg::PH_FILE_HDR;
            pos_reg   <= '0;
            fmt_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                fmt_reg   <= fmt_next;
                rem_reg   <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == pcapdf_pkg::PH_FILE_HDR ||
                       phase_reg == pcapdf_pkg::PH_REC_HDR))
        begin
            header_bytes_reg[pos_reg] <= b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[0] <= r0;
            q_reg[1] <= r1;
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].end_of_record;
    assign m_tdata  = {6'd0,
                       q_reg[0].payload_byte,
                       q_reg[0].original_length,
                       q_reg[0].captured_length,
                       q_reg[0].subseconds,
                       q_reg[0].seconds,
                       q_reg[0].link_type,
                       q_reg[0].snap_length,
                       q_reg[0].ver_minor,
                       q_reg[0].ver_major,
                       q_reg[0].format};

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives capture files byte by byte into the deframer: valid files in all
// four formats, bad magics, truncated files, empty and huge records. Every
// result is checked field by field against a cycle-free software deframer.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 600_000;
    localparam int RANDOM_BYTES = 1450;
    localparam int MAX_PAYLOAD = 48;   // most bytes actually written for one record

    // magic selectors beyond the four valid formats
    localparam int MAGIC_BAD_NEAR = 4;
    localparam int MAGIC_RANDOM   = 5;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int CAP_EMPTY  = 0;
    localparam int CAP_SMALL  = 1;
    localparam int CAP_MEDIUM = 2;
    localparam int CAP_HUGE   = 3;
    localparam int CAP_MIXED  = 4;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;   // hold this item until every result is out
    } file_item_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = 8'd0;
    logic                           s_tlast  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pcapdf_pkg::TDATA_W-1:0] m_tdata;
    logic [pcapdf_pkg::TUSER_W-1:0] m_tuser;
    logic                           m_tlast;

    file_item_t           feed_q[$];
    logic [7:0]           file_img[$];
    pcapdf_pkg::result_t  decoded_q[$];
    int                   fed_bytes  = 0;
    int                   fail_count = 0;
    int                   cycle_count = 0;

    // software deframer state
    pcapdf_pkg::phase_t   df_phase = pcapdf_pkg::PH_FILE_HDR;
    int                   df_pos   = 0;
    logic [7:0]           df_hdr[pcapdf_pkg::GLOBAL_HDR_LEN];
    logic [1:0]           df_fmt   = pcapdf_pkg::FMT_LE_US;
    logic [31:0]          df_left  = '0;

    // driver / receiver pacing
    int          gap_left   = 0;
    int          burst_left = 0;
    int          ready_mode = 0;
    int          mode_left  = 0;
    int          ready_tick = 0;
    file_item_t  cur_item;

    pcap_stream_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // software deframer
    // ------------------------------------------------------------------
    function automatic logic [15:0] hdr_half(int off);
        return df_fmt[0] ? {df_hdr[off], df_hdr[off + 1]} : {df_hdr[off + 1], df_hdr[off]};
    endfunction

    function automatic logic [31:0] hdr_word(int off);
        return df_fmt[0] ? {hdr_half(off), hdr_half(off + 2)}
                         : {hdr_half(off + 2), hdr_half(off)};
    endfunction

    function automatic pcapdf_pkg::result_t fresh_result(pcapdf_pkg::kind_t k);
        pcapdf_pkg::result_t r;
        r        = '0;
        r.kind   = k;
        r.format = (k == pcapdf_pkg::K_BAD_MAGIC) ? pcapdf_pkg::FMT_LE_US : df_fmt;
        return r;
    endfunction

    function automatic void deframe_byte(logic [7:0] b, logic eof);
        pcapdf_pkg::result_t r;
        logic [31:0]         magic;
        logic [31:0]         cap;
        case (df_phase)
            pcapdf_pkg::PH_FILE_HDR:
            begin
                df_hdr[df_pos] = b;
                if (df_pos == 3)
                begin
                    magic = {df_hdr[0], df_hdr[1], df_hdr[2], df_hdr[3]};
                    if (magic == {pcapdf_pkg::MAGIC_D4, pcapdf_pkg::MAGIC_C3,
                                  pcapdf_pkg::MAGIC_B2, pcapdf_pkg::MAGIC_A1})
                        df_fmt = pcapdf_pkg::FMT_LE_US;
                    else if (magic == {pcapdf_pkg::MAGIC_A1, pcapdf_pkg::MAGIC_B2,
                                       pcapdf_pkg::MAGIC_C3, pcapdf_pkg::MAGIC_D4})
                        df_fmt = pcapdf_pkg::FMT_BE_US;
                    else if (magic == {pcapdf_pkg::MAGIC_4D, pcapdf_pkg::MAGIC_3C,
                                       pcapdf_pkg::MAGIC_B2, pcapdf_pkg::MAGIC_A1})
                        df_fmt = pcapdf_pkg::FMT_LE_NS;
                    else if (magic == {pcapdf_pkg::MAGIC_A1, pcapdf_pkg::MAGIC_B2,
                                       pcapdf_pkg::MAGIC_3C, pcapdf_pkg::MAGIC_4D})
                        df_fmt = pcapdf_pkg::FMT_BE_NS;
                    else
                    begin
                        df_fmt   = pcapdf_pkg::FMT_LE_US;
                        df_phase = pcapdf_pkg::PH_SKIP;
                    end
                end
                if (df_phase == pcapdf_pkg::PH_SKIP)
                    decoded_q.push_back(fresh_result(pcapdf_pkg::K_BAD_MAGIC));
                else if (df_pos == pcapdf_pkg::GLOBAL_HDR_LEN - 1)
                begin
                    r             = fresh_result(pcapdf_pkg::K_FILE_HDR);
                    r.ver_major   = hdr_half(4);
                    r.ver_minor   = hdr_half(6);
                    r.snap_length = hdr_word(16);
                    r.link_type   = hdr_word(20);
                    decoded_q.push_back(r);
                    df_phase = pcapdf_pkg::PH_REC_HDR;
                    df_pos   = 0;
                end
                else
                begin
                    df_pos++;
                    if (eof)
                        decoded_q.push_back(fresh_result(pcapdf_pkg::K_TRUNC));
                end
            end
            pcapdf_pkg::PH_REC_HDR:
            begin
                df_hdr[df_pos] = b;
                if (df_pos == pcapdf_pkg::RECORD_HDR_LEN - 1)
                begin
                    cap               = hdr_word(8);
                    r                 = fresh_result(pcapdf_pkg::K_REC_HDR);
                    r.seconds         = hdr_word(0);
                    r.subseconds      = hdr_word(4);
                    r.captured_length = cap;
                    r.original_length = hdr_word(12);
                    r.end_of_record   = (cap == 0);
                    decoded_q.push_back(r);
                    df_left = cap;
                    df_pos  = 0;
                    if (cap != 0)
                    begin
                        df_phase = pcapdf_pkg::PH_PAYLOAD;
                        if (eof)
                            decoded_q.push_back(fresh_result(pcapdf_pkg::K_TRUNC));
                    end
                end
                else
                begin
                    df_pos++;
                    if (eof)
                        decoded_q.push_back(fresh_result(pcapdf_pkg::K_TRUNC));
                end
            end
            pcapdf_pkg::PH_PAYLOAD:
            begin
                if (df_left != 0)
                    df_left--;
                r               = fresh_result(pcapdf_pkg::K_PAYLOAD);
                r.payload_byte  = b;
                r.end_of_record = (df_left == 0);
                decoded_q.push_back(r);
                if (df_left == 0)
                begin
                    df_phase = pcapdf_pkg::PH_REC_HDR;
                    df_pos   = 0;
                end
                else if (eof)
                    decoded_q.push_back(fresh_result(pcapdf_pkg::K_TRUNC));
            end
            default: ;   // bad magic: drop bytes until end of file
        endcase
        if (eof)
        begin
            df_phase = pcapdf_pkg::PH_FILE_HDR;
            df_pos   = 0;
            df_left  = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // file generation
    // ------------------------------------------------------------------
    function automatic logic [31:0] magic_of(int f);
        case (f)
            pcapdf_pkg::FMT_LE_US: return {pcapdf_pkg::MAGIC_D4, pcapdf_pkg::MAGIC_C3,
                                           pcapdf_pkg::MAGIC_B2, pcapdf_pkg::MAGIC_A1};
            pcapdf_pkg::FMT_BE_US: return {pcapdf_pkg::MAGIC_A1, pcapdf_pkg::MAGIC_B2,
                                           pcapdf_pkg::MAGIC_C3, pcapdf_pkg::MAGIC_D4};
            pcapdf_pkg::FMT_LE_NS: return {pcapdf_pkg::MAGIC_4D, pcapdf_pkg::MAGIC_3C,
                                           pcapdf_pkg::MAGIC_B2, pcapdf_pkg::MAGIC_A1};
            default:               return {pcapdf_pkg::MAGIC_A1, pcapdf_pkg::MAGIC_B2,
                                           pcapdf_pkg::MAGIC_3C, pcapdf_pkg::MAGIC_4D};
        endcase
    endfunction

    function automatic logic [31:0] field_val(int fill);
        case (fill)
            FILL_ZERO: return '0;
            FILL_ONES: return '1;
            default:   return $urandom;
        endcase
    endfunction

    function automatic void put_bytes(logic [31:0] v, int n, logic big);
        for (int i = 0; i < n; i++)
            file_img.push_back(big ? v[8 * (n - 1 - i) +: 8] : v[8 * i +: 8]);
    endfunction

    function automatic void make_file(int fmt, int n_rec, int cap_mode, int fill);
        logic [31:0] magic;
        logic        big;
        logic [31:0] cap;
        logic [31:0] pay_word;
        int          mode;
        int          r;
        int          n_pay;
        file_img.delete();
        if (fmt == MAGIC_BAD_NEAR)
            magic = magic_of($urandom_range(0, 3)) ^ (32'd1 << $urandom_range(0, 31));
        else if (fmt == MAGIC_RANDOM)
            magic = $urandom;
        else
            magic = magic_of(fmt);
        big = (fmt < MAGIC_BAD_NEAR) ? fmt[0] : 1'($urandom_range(0, 1));
        put_bytes(magic, 4, 1'b1);
        put_bytes(field_val(fill), 2, big);   // major
        put_bytes(field_val(fill), 2, big);   // minor
        put_bytes(field_val(fill), 4, big);   // time zone
        put_bytes(field_val(fill), 4, big);   // accuracy
        put_bytes(field_val(fill), 4, big);   // snap length
        put_bytes(field_val(fill), 4, big);   // link type
        for (int i = 0; i < n_rec; i++)
        begin
            mode = cap_mode;
            if (cap_mode == CAP_MIXED)
            begin
                r = $urandom_range(0, 19);
                mode = (r == 0) ? CAP_HUGE : (r < 4) ? CAP_EMPTY :
                       (r < 7) ? CAP_MEDIUM : CAP_SMALL;
            end
            case (mode)
                CAP_EMPTY:  cap = '0;
                CAP_SMALL:  cap = $urandom_range(1, 12);
                CAP_MEDIUM: cap = $urandom_range(13, 60);
                default:    cap = $urandom_range(32'hffff_ffff, 32'h0001_0000);
            endcase
            put_bytes(field_val(fill), 4, big);
            put_bytes(field_val(fill), 4, big);
            put_bytes(cap, 4, big);
            put_bytes(field_val(fill), 4, big);
            n_pay = (cap > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cap);
            for (int j = 0; j < n_pay; j++)
            begin
                pay_word = field_val(fill);
                file_img.push_back(pay_word[7:0]);
            end
        end
    endfunction

    // queue the first len bytes of the image; len <= 0 sends it whole
    function automatic void send_file(int len, logic drain);
        file_item_t it;
        if (len <= 0 || len > file_img.size())
            len = file_img.size();
        for (int i = 0; i < len; i++)
        begin
            it.data  = file_img[i];
            it.last  = (i == len - 1);
            it.drain = drain && (i == 0);
            feed_q.push_back(it);
        end
        fed_bytes += len;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        else if (r < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 15);
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of items with random gaps; predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'd0;
            s_tlast    <= 1'b0;
            gap_left   = 0;
            burst_left = $urandom_range(1, 30);
            df_phase   = pcapdf_pkg::PH_FILE_HDR;
            df_pos     = 0;
            df_fmt     = pcapdf_pkg::FMT_LE_US;
            df_left    = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (feed_q.size() != 0 && !(feed_q[0].drain && decoded_q.size() != 0))
                begin
                    cur_item = feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_item.data;
                    s_tlast  <= cur_item.last;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = pick_gap();
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern switches among four modes at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_mode = 0;
            mode_left  = 0;
            ready_tick = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 300);
            end
            else
                mode_left--;
            ready_tick++;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= (ready_tick % 4) != 0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        pcapdf_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("result with nothing pending: kind %0d", m_tuser);
                fail_count++;
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("kind",            want.kind,            m_tuser);
                check_field("format",          want.format,          m_tdata[1:0]);
                check_field("ver_major",       want.ver_major,       m_tdata[17:2]);
                check_field("ver_minor",       want.ver_minor,       m_tdata[33:18]);
                check_field("snap_length",     want.snap_length,     m_tdata[65:34]);
                check_field("link_type",       want.link_type,       m_tdata[97:66]);
                check_field("seconds",         want.seconds,         m_tdata[129:98]);
                check_field("subseconds",      want.subseconds,      m_tdata[161:130]);
                check_field("captured_length", want.captured_length, m_tdata[193:162]);
                check_field("original_length", want.original_length, m_tdata[225:194]);
                check_field("payload_byte",    want.payload_byte,    m_tdata[233:226]);
                check_field("tdata_pad",       32'd0,                m_tdata[239:234]);
                check_field("end_of_record",   want.end_of_record,   m_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int  r;
        int  fmt;
        int  len;
        bit  first;

        // short file, stops inside the magic
        make_file(pcapdf_pkg::FMT_LE_US, 0, CAP_EMPTY, FILL_RANDOM);
        send_file(2, 1'b0);
        // one-byte file
        make_file(pcapdf_pkg::FMT_BE_NS, 0, CAP_EMPTY, FILL_RANDOM);
        send_file(1, 1'b0);
        // bad magic ending on its fourth byte, then one with trailing bytes
        make_file(MAGIC_BAD_NEAR, 0, CAP_EMPTY, FILL_RANDOM);
        send_file(4, 1'b0);
        make_file(MAGIC_RANDOM, 1, CAP_SMALL, FILL_RANDOM);
        send_file(0, 1'b0);
        // end inside global header, then right after it
        make_file(pcapdf_pkg::FMT_LE_NS, 0, CAP_EMPTY, FILL_RANDOM);
        send_file(10, 1'b0);
        make_file(pcapdf_pkg::FMT_BE_US, 0, CAP_EMPTY, FILL_RANDOM);
        send_file(0, 1'b0);
        // empty record ends the file cleanly
        make_file(pcapdf_pkg::FMT_LE_NS, 1, CAP_EMPTY, FILL_RANDOM);
        send_file(0, 1'b0);
        // end inside a record header, and on a header with payload pending
        make_file(pcapdf_pkg::FMT_BE_NS, 1, CAP_SMALL, FILL_RANDOM);
        send_file(pcapdf_pkg::GLOBAL_HDR_LEN + 7, 1'b0);
        make_file(pcapdf_pkg::FMT_BE_NS, 1, CAP_SMALL, FILL_RANDOM);
        send_file(pcapdf_pkg::GLOBAL_HDR_LEN + pcapdf_pkg::RECORD_HDR_LEN, 1'b0);
        // end inside payload, and a whole multi-record file
        make_file(pcapdf_pkg::FMT_BE_US, 1, CAP_MEDIUM, FILL_RANDOM);
        send_file(pcapdf_pkg::GLOBAL_HDR_LEN + pcapdf_pkg::RECORD_HDR_LEN + 3, 1'b0);
        make_file(pcapdf_pkg::FMT_LE_US, 3, CAP_SMALL, FILL_RANDOM);
        send_file(0, 1'b0);
        // huge captured length, cut short by end of file
        make_file(pcapdf_pkg::FMT_LE_US, 1, CAP_HUGE, FILL_RANDOM);
        send_file(0, 1'b0);
        // field extremes
        make_file(pcapdf_pkg::FMT_LE_US, 2, CAP_SMALL, FILL_ZERO);
        send_file(0, 1'b0);
        make_file(pcapdf_pkg::FMT_BE_NS, 2, CAP_SMALL, FILL_ONES);
        send_file(0, 1'b0);

        first     = 1'b1;
        while (fed_bytes < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            fmt = (r < 80) ? $urandom_range(0, 3) : (r < 90) ? MAGIC_BAD_NEAR : MAGIC_RANDOM;
            make_file(fmt, $urandom_range(0, 4), CAP_MIXED,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(FILL_ZERO, FILL_ONES)
                                                  : FILL_RANDOM);
            len = ($urandom_range(0, 99) < 65) ? 0 : $urandom_range(1, file_img.size());
            send_file(len, first || ($urandom_range(0, 9) == 0));
            first = 1'b0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || s_tvalid)
            @(negedge clk);
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/pcapdf_pkg.sv
rtl/pcap_stream_deframer_core.sv
test/tb_top.sv
